// ----- design/qdse_pkg.sv -----
// Shared types, constants and helpers for the quadrature decoder speed estimator.
// Used by qdse_front, qdse_div and quadrature_decoder_speed_estimator.
package qdse_pkg;

    // Shared divider geometry
    localparam int DIV_W     = 60;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int DIVR_W    = 32;

    // Wide signed datapath for rate terms, smoothing accumulator width
    localparam int WIDE_W = 62;
    localparam int ACC_W  = 50;
    localparam int RPM_W  = 38;

    // Counts per second in Q24.8: 1e6 us/s times 256
    localparam logic [27:0] RATE_SCALE = 28'd256000000;
    localparam logic [16:0] ALPHA_ONE  = 17'd65536;
    localparam logic [6:0]  SEC_PER_MIN = 7'd60;

    // Direction codes, two bit signed
    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_POS  = 2'sb01;
    localparam logic signed [1:0] DIR_NEG  = 2'sb11;

    // Configuration register indexes
    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_ALPHA  = 2'd1;
    localparam logic [1:0] REG_CPR    = 2'd2;
    localparam logic [1:0] REG_INDEX  = 2'd3;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } qdse_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } qdse_div_rsp_t;

    // Position tracker status
    typedef struct packed {
        logic signed [31:0] count;
        logic signed [1:0]  direction;
        logic [31:0]        edge_interval;
        logic               index_flag;
    } qdse_pos_t;

    // Clamp a wide signed value to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] max_v;
        logic signed [WIDE_W-1:0] min_v;
        max_v = WIDE_W'(64'sd2147483647);
        min_v = -WIDE_W'(64'sd2147483648);
        if (v > max_v)
            return 32'sh7FFFFFFF;
        else if (v < min_v)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

// ----- design/quadrature_decoder_speed_estimator.sv -----
// Quadrature decoder with windowed speed estimate: top level and report sequencer.
// A sample that closes no window is taken without holding the input; the next can follow at once.
// A sample that closes a window holds the input for three passes
// through the shared divider (window rate, edge rate, RPM) and eight steps.
// Zero elapsed time or no edge interval skips its pass; an output stall holds the input longer.
// Reset clears position, timing, smoothing state and flags; registers take defaults.
module quadrature_decoder_speed_estimator
    import qdse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               a_level,
    input  logic               b_level,
    input  logic               z_level,
    input  logic [31:0]        now_us,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] position,
    output logic signed [31:0] speed_cps_q8,
    output logic signed [31:0] rpm_q8,
    output logic [31:0]        edge_interval_us,
    output logic signed [1:0]  last_direction,
    output logic               index_seen
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WMUL = 4'd1;
    localparam logic [3:0] S_WDIV = 4'd2;
    localparam logic [3:0] S_EDGE = 4'd3;
    localparam logic [3:0] S_EDIV = 4'd4;
    localparam logic [3:0] S_MIX1 = 4'd5;
    localparam logic [3:0] S_MIX2 = 4'd6;
    localparam logic [3:0] S_RND1 = 4'd7;
    localparam logic [3:0] S_RND2 = 4'd8;
    localparam logic [3:0] S_RMUL = 4'd9;
    localparam logic [3:0] S_RDIV = 4'd10;
    localparam logic [3:0] S_EMIT = 4'd11;

    // Configuration registers
    logic [31:0] window_reg;
    logic [16:0] alpha_reg;
    logic [15:0] cpr_reg;
    logic        index_en_reg;

    // Sequencer and datapath registers
    logic [3:0]               state_reg, state_next;
    logic [31:0]              now_reg;
    logic [31:0]              elapsed_reg;
    logic [31:0]              wsc_reg;
    logic [31:0]              wst_reg;
    logic signed [31:0]       smoothed_reg;
    logic signed [WIDE_W-1:0] win_reg;
    logic signed [WIDE_W-1:0] inst_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     neg_reg;
    logic signed [31:0]       rpm_reg;

    // Output registers
    logic               out_valid_reg;
    logic signed [31:0] pos_out_reg;
    logic signed [31:0] speed_out_reg;
    logic signed [31:0] rpm_out_reg;
    logic [31:0]        ival_out_reg;
    logic signed [1:0]  dir_out_reg;
    logic               idx_out_reg;

    logic          take;
    logic          due;
    logic          emit;
    qdse_pos_t     pos;
    qdse_div_req_t div_req;
    qdse_div_rsp_t div_rsp;

    logic signed [31:0]       delta;
    logic [31:0]              delta_mag;
    logic [DIV_W-1:0]         win_prod;
    logic [16:0]              alpha_eff;
    logic [16:0]              beta;
    logic [15:0]              cpr_eff;
    logic signed [31:0]       inst32;
    logic signed [ACC_W-1:0]  mix_a;
    logic signed [ACC_W-1:0]  mix_b;
    logic signed [ACC_W-1:0]  acc_mag;
    logic [33:0]              rnd_q;
    logic signed [RPM_W-1:0]  rpm_prod;
    logic [RPM_W-1:0]         rpm_mag;
    logic signed [WIDE_W-1:0] div_q_wide;
    logic signed [WIDE_W-1:0] edge_sum;

    qdse_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .a_level      (a_level),
        .b_level      (b_level),
        .z_level      (z_level),
        .now_us       (now_us),
        .index_enable (index_en_reg),
        .pos          (pos)
    );

    qdse_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Handshake and window check
    assign in_stall = state_reg != S_IDLE;
    assign take     = in_valid && !in_stall;
    assign due      = (now_us - wst_reg) >= window_reg;
    assign emit     = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    // Arithmetic operands
    always_comb
    begin
        delta      = $signed(pos.count - $signed(wsc_reg));
        delta_mag  = delta[31] ? 32'(-delta) : 32'(delta);
        win_prod   = DIV_W'(delta_mag) * DIV_W'(RATE_SCALE);
        alpha_eff  = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
        beta       = ALPHA_ONE - alpha_eff;
        cpr_eff    = (cpr_reg == 16'd0) ? 16'd1 : cpr_reg;
        inst32     = sat32(inst_reg);
        mix_a      = ACC_W'($signed({1'b0, alpha_eff})) * ACC_W'(inst32);
        mix_b      = ACC_W'($signed({1'b0, beta})) * ACC_W'(smoothed_reg);
        acc_mag    = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
        rnd_q      = acc_reg[ACC_W-1:16];
        rpm_prod   = RPM_W'(smoothed_reg) * RPM_W'($signed({1'b0, SEC_PER_MIN}));
        rpm_mag    = rpm_prod[RPM_W-1] ? RPM_W'(-rpm_prod) : RPM_W'(rpm_prod);
        div_q_wide = $signed({2'b00, div_rsp.quotient});
        edge_sum   = win_reg + div_q_wide;
    end

    // Drive the shared divider from the sequencer
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            S_WMUL:
            begin
                div_req.start    = elapsed_reg != 32'd0;
                div_req.dividend = win_prod + DIV_W'(elapsed_reg >> 1);
                div_req.divisor  = elapsed_reg;
            end
            S_EDGE:
            begin
                div_req.start    = pos.edge_interval != 32'd0;
                div_req.dividend = DIV_W'(RATE_SCALE) + DIV_W'(pos.edge_interval >> 1);
                div_req.divisor  = pos.edge_interval;
            end
            S_RMUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(rpm_mag) + DIV_W'(cpr_eff >> 1);
                div_req.divisor  = DIVR_W'(cpr_eff);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (take && due) state_next = S_WMUL;
            S_WMUL: state_next = (elapsed_reg != 32'd0) ? S_WDIV : S_EDGE;
            S_WDIV: if (div_rsp.done) state_next = S_EDGE;
            S_EDGE: state_next = (pos.edge_interval != 32'd0) ? S_EDIV : S_MIX1;
            S_EDIV: if (div_rsp.done) state_next = S_MIX1;
            S_MIX1: state_next = S_MIX2;
            S_MIX2: state_next = S_RND1;
            S_RND1: state_next = S_RND2;
            S_RND2: state_next = S_RMUL;
            S_RMUL: state_next = S_RDIV;
            S_RDIV: if (div_rsp.done) state_next = S_EMIT;
            S_EMIT: if (emit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= 32'd50000;
            alpha_reg    <= 17'd19661;
            cpr_reg      <= 16'd1024;
            index_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW: window_reg   <= cfg_data;
                REG_ALPHA:  alpha_reg    <= cfg_data[16:0];
                REG_CPR:    cpr_reg      <= cfg_data[15:0];
                REG_INDEX:  index_en_reg <= cfg_data[0];
                default:    index_en_reg <= index_en_reg;
            endcase
        end
    end

    // Control state and window bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wsc_reg       <= '0;
            wst_reg       <= '0;
            smoothed_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_RND2)
                smoothed_reg <= sat32(neg_reg ? -WIDE_W'($signed({1'b0, rnd_q}))
                                              :  WIDE_W'($signed({1'b0, rnd_q})));
            // Close the window and present the transaction
            if (emit)
            begin
                wsc_reg       <= pos.count;
                wst_reg       <= now_reg;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Report datapath
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            now_reg     <= now_us;
            elapsed_reg <= now_us - wst_reg;
        end
        unique case (state_reg)
            S_WMUL:
            begin
                neg_reg <= delta[31];
                win_reg <= '0;
            end
            S_WDIV:
            begin
                if (div_rsp.done)
                    win_reg <= neg_reg ? -div_q_wide : div_q_wide;
            end
            S_EDGE:
            begin
                inst_reg <= win_reg;
            end
            S_EDIV:
            begin
                // halve, truncating toward zero
                if (div_rsp.done)
                    inst_reg <= (edge_sum + WIDE_W'($signed({1'b0, edge_sum[WIDE_W-1]})))
                                >>> 1;
            end
            S_MIX1:
            begin
                acc_reg <= mix_a;
            end
            S_MIX2:
            begin
                acc_reg <= acc_reg + mix_b;
            end
            S_RND1:
            begin
                neg_reg <= acc_reg[ACC_W-1];
                acc_reg <= acc_mag + ACC_W'(32768);
            end
            S_RMUL:
            begin
                neg_reg <= rpm_prod[RPM_W-1];
            end
            S_RDIV:
            begin
                if (div_rsp.done)
                    rpm_reg <= sat32(neg_reg ? -div_q_wide : div_q_wide);
            end
            default:
            begin
                neg_reg <= neg_reg;
            end
        endcase
        if (emit)
        begin
            pos_out_reg   <= pos.count;
            speed_out_reg <= smoothed_reg;
            rpm_out_reg   <= rpm_reg;
            ival_out_reg  <= pos.edge_interval;
            dir_out_reg   <= pos.direction;
            idx_out_reg   <= pos.index_flag;
        end
    end

    assign out_valid        = out_valid_reg;
    assign position         = pos_out_reg;
    assign speed_cps_q8     = speed_out_reg;
    assign rpm_q8           = rpm_out_reg;
    assign edge_interval_us = ival_out_reg;
    assign last_direction   = dir_out_reg;
    assign index_seen       = idx_out_reg;

endmodule

// ----- design/qdse_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on qdse_pkg for widths and request/response structs.
module qdse_div
    import qdse_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  qdse_div_req_t req,
    output qdse_div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVR_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIVR_W-1:0]    dvs_reg, dvs_next;

    logic [DIVR_W:0]      shifted;
    logic [DIVR_W+1:0]    diff;

    // One restoring step: shift in the next dividend bit, try a subtract
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIVR_W+1])
            begin
                rem_next = diff[DIVR_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIVR_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- design/qdse_front.sv -----
// Quadrature X4 decode, edge interval timing and sticky index flag.
// Depends on qdse_pkg for the status struct and direction codes.
module qdse_front
    import qdse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic        a_level,
    input  logic        b_level,
    input  logic        z_level,
    input  logic [31:0] now_us,
    input  logic        index_enable,
    output qdse_pos_t   pos
);

    logic               prev_a_reg, prev_b_reg, prev_z_reg;
    logic signed [31:0] count_reg;
    logic signed [1:0]  dir_reg;
    logic [31:0]        last_time_reg;
    logic [31:0]        interval_reg;
    logic               index_reg;

    logic a_chg, b_chg, edge_hit, step_up;

    // Decode the step direction; a change on A wins over B
    always_comb
    begin
        a_chg    = a_level != prev_a_reg;
        b_chg    = b_level != prev_b_reg;
        edge_hit = take && (a_chg || b_chg);
        step_up  = a_chg ? (a_level == b_level) : (a_level != b_level);
    end

    // Track pins, position and timing on every accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_a_reg    <= 1'b0;
            prev_b_reg    <= 1'b0;
            prev_z_reg    <= 1'b0;
            count_reg     <= '0;
            dir_reg       <= DIR_NONE;
            last_time_reg <= '0;
            interval_reg  <= '0;
            index_reg     <= 1'b0;
        end
        else if (take)
        begin
            prev_a_reg <= a_level;
            prev_b_reg <= b_level;
            prev_z_reg <= z_level;
            if (edge_hit)
            begin
                count_reg     <= step_up ? count_reg + 32'sd1 : count_reg - 32'sd1;
                dir_reg       <= step_up ? DIR_POS : DIR_NEG;
                interval_reg  <= now_us - last_time_reg;
                last_time_reg <= now_us;
            end
            if (index_enable && z_level && !prev_z_reg)
                index_reg <= 1'b1;
        end
    end

    assign pos.count         = count_reg;
    assign pos.direction     = dir_reg;
    assign pos.edge_interval = interval_reg;
    assign pos.index_flag    = index_reg;

endmodule

// ----- bench/speed_report_checker.sv -----
// Checker for the quadrature decoder speed estimator: snoops the register port and both
// channels, predicts each speed report and compares it field by field.
// Depends on qdse_pkg for direction codes, register indexes and rate constants.
`timescale 1ns / 100ps

module speed_report_checker
    import qdse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               a_level,
    input  logic               b_level,
    input  logic               z_level,
    input  logic [31:0]        now_us,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] position,
    input  logic signed [31:0] speed_cps_q8,
    input  logic signed [31:0] rpm_q8,
    input  logic [31:0]        edge_interval_us,
    input  logic signed [1:0]  last_direction,
    input  logic               index_seen,
    output int                 mismatches,
    output int                 open_reports
);

    localparam int     MaxReported = 10;
    localparam longint UsRateQ8    = longint'(RATE_SCALE);
    localparam longint AlphaOne    = longint'(ALPHA_ONE);
    localparam longint SecPerMin   = longint'(SEC_PER_MIN);

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] speed;
        logic signed [31:0] rpm;
        logic [31:0]        interval;
        logic signed [1:0]  direction;
        logic               index;
    } speed_report_t;

    speed_report_t expected_reports[$];

    // register copies
    logic [31:0]        window_len = 32'd50000;
    logic [16:0]        alpha_q16  = 17'd19661;
    logic [15:0]        cpr        = 16'd1024;
    logic               index_en   = 1'b1;

    // decoder and estimator state
    logic               last_a = 1'b0;
    logic               last_b = 1'b0;
    logic               last_z = 1'b0;
    logic [31:0]        pos_count = '0;
    logic signed [1:0]  last_dir = DIR_NONE;
    logic [31:0]        last_edge_at = '0;
    logic [31:0]        edge_gap = '0;
    logic               index_latched = 1'b0;
    logic [31:0]        win_start_count = '0;
    logic [31:0]        win_start_at = '0;
    logic signed [31:0] smoothed = '0;
    int                 error_total = 0;

    // signed over positive, rounded half away from zero
    function automatic longint round_div(input longint num, input longint unsigned den);
        longint unsigned mag;
        longint unsigned quo;
        mag = (num < 0) ? -num : num;
        quo = (mag + den / 2) / den;
        return (num < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        else if (v < -longint'(64'sd2147483648))
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Advance the decoder by one pin sample; queue a report when the window closes
    task automatic advance_decoder(input logic a, input logic b, input logic z,
                                   input logic [31:0] now);
        logic signed [1:0]  step_dir;
        logic [31:0]        elapsed;
        logic signed [31:0] delta;
        logic signed [31:0] inst_rate;
        logic signed [31:0] rpm;
        longint             win_rate;
        longint             edge_rate;
        longint             inst;
        longint             weight;
        longint             mix;
        longint unsigned    cpr_div;
        speed_report_t      rep;

        // count the edge; a change of both pins follows the A rule
        if (a != last_a || b != last_b)
        begin
            if (a != last_a)
                step_dir = (a == b) ? DIR_POS : DIR_NEG;
            else
                step_dir = (a != b) ? DIR_POS : DIR_NEG;
            pos_count = (step_dir == DIR_POS) ? pos_count + 32'd1 : pos_count - 32'd1;
            last_dir = step_dir;
            edge_gap = now - last_edge_at;
            last_edge_at = now;
        end
        last_a = a;
        last_b = b;

        // latch index rise only while detection is on
        if (index_en && z && !last_z)
            index_latched = 1'b1;
        last_z = z;

        elapsed = now - win_start_at;
        if (elapsed >= window_len)
        begin
            delta = pos_count - win_start_count;
            win_rate = 0;
            if (elapsed != 0)
                win_rate = round_div(longint'(delta) * UsRateQ8, elapsed);

            // average with the edge rate when an interval is known
            inst = win_rate;
            if (edge_gap != 0)
            begin
                edge_rate = (UsRateQ8 + longint'(edge_gap / 2)) / longint'(edge_gap);
                inst = (win_rate + edge_rate) / 2;
            end
            inst_rate = clamp32(inst);

            // exponential smoothing, weight capped at one
            weight = (alpha_q16 > ALPHA_ONE) ? AlphaOne : longint'(alpha_q16);
            mix = weight * longint'(inst_rate) + (AlphaOne - weight) * longint'(smoothed);
            smoothed = clamp32(round_div(mix, 65536));

            cpr_div = (cpr == 0) ? 1 : cpr;
            rpm = clamp32(round_div(longint'(smoothed) * SecPerMin, cpr_div));

            win_start_count = pos_count;
            win_start_at = now;

            rep.position = pos_count;
            rep.speed = smoothed;
            rep.rpm = rpm;
            rep.interval = edge_gap;
            rep.direction = last_dir;
            rep.index = index_latched;
            expected_reports.push_back(rep);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            error_total++;
            if (error_total <= MaxReported)
                $display("checker: %s mismatch, expected 0x%08h, got 0x%08h", name, want, got);
        end
    endtask

    // Compare an accepted report with the oldest prediction
    task automatic check_report();
        speed_report_t want;
        if (expected_reports.size() == 0)
        begin
            error_total++;
            if (error_total <= MaxReported)
                $display("checker: report with none expected, position 0x%08h", position);
        end
        else
        begin
            want = expected_reports.pop_front();
            check_field("position", want.position, position);
            check_field("speed_cps_q8", want.speed, speed_cps_q8);
            check_field("rpm_q8", want.rpm, rpm_q8);
            check_field("edge_interval_us", want.interval, edge_interval_us);
            check_field("last_direction", {30'd0, want.direction}, {30'd0, last_direction});
            check_field("index_seen", {31'd0, want.index}, {31'd0, index_seen});
        end
    endtask

    // Track registers and transactions in the order the block sees them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len = 32'd50000;
            alpha_q16 = 17'd19661;
            cpr = 16'd1024;
            index_en = 1'b1;
            last_a = 1'b0;
            last_b = 1'b0;
            last_z = 1'b0;
            pos_count = '0;
            last_dir = DIR_NONE;
            last_edge_at = '0;
            edge_gap = '0;
            index_latched = 1'b0;
            win_start_count = '0;
            win_start_at = '0;
            smoothed = '0;
            error_total = 0;
            expected_reports.delete();
            mismatches <= 0;
            open_reports <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW: window_len = cfg_data;
                    REG_ALPHA:  alpha_q16 = cfg_data[16:0];
                    REG_CPR:    cpr = cfg_data[15:0];
                    REG_INDEX:  index_en = cfg_data[0];
                    default:    ;
                endcase
            end
            if (in_valid && !in_stall)
                advance_decoder(a_level, b_level, z_level, now_us);
            if (out_valid && !out_stall)
                check_report();
            mismatches <= error_total;
            open_reports <= expected_reports.size();
        end
    end

endmodule

// ----- bench/tb_quadrature_decoder_speed_estimator.sv -----
// Testbench top for the quadrature decoder speed estimator: clock, reset, register
// setup, pin sample stimulus and output stall pattern; checking is in speed_report_checker.
// Depends on qdse_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_quadrature_decoder_speed_estimator;
    import qdse_pkg::*;

    localparam int IdleLimit    = 4000;
    localparam int SettleCycles = 300;
    localparam int RandomPhases = 8;
    localparam int PhaseItems   = 110;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = REG_WINDOW;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               a_level = 1'b0;
    logic               b_level = 1'b0;
    logic               z_level = 1'b0;
    logic [31:0]        now_us = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] position;
    logic signed [31:0] speed_cps_q8;
    logic signed [31:0] rpm_q8;
    logic [31:0]        edge_interval_us;
    logic signed [1:0]  last_direction;
    logic               index_seen;
    int                 mismatches;
    int                 open_reports;

    // sender pacing, receiver stall pattern, watchdog
    int                 burst_left = 0;
    int                 max_burst = 8;
    int                 max_gap = 4;
    int                 stall_mode = 1;
    int                 stall_left = 0;
    int                 idle_cycles = 0;

    // current pin levels {a, b}, walk direction, last timestamp
    logic [1:0]         pins_ab = 2'b00;
    logic               run_fwd = 1'b1;
    logic [31:0]        stamp = '0;

    quadrature_decoder_speed_estimator u_top (.*);

    speed_report_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hold or release the output stall in runs of random length
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
        begin
            out_stall <= (stall_mode != 0) && ($urandom_range(0, 2) == 0);
            stall_left <= $urandom_range(0, (stall_mode == 2) ? 24 : 3);
        end
    end

    // Drop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles < IdleLimit)
            idle_cycles <= idle_cycles + 1;
        else
        begin
            $display("tb_quadrature_decoder_speed_estimator: done, errors");
            $finish;
        end
    end

    // One quadrature step along the Gray sequence 00, 01, 11, 10 (forward counts up)
    function automatic logic [1:0] gray_next(input logic [1:0] ab, input logic fwd);
        logic [1:0] nxt;
        case (ab)
            2'b00:   nxt = fwd ? 2'b01 : 2'b10;
            2'b01:   nxt = fwd ? 2'b11 : 2'b00;
            2'b11:   nxt = fwd ? 2'b10 : 2'b01;
            default: nxt = fwd ? 2'b00 : 2'b11;
        endcase
        return nxt;
    endfunction

    // Write all four registers on consecutive cycles
    task automatic load_config(input logic [31:0] win_len, input logic [31:0] alpha,
                               input logic [31:0] cpr_val, input logic [31:0] idx_on);
        cfg_we <= 1'b1;
        cfg_index <= REG_WINDOW;
        cfg_data <= win_len;
        @(posedge clk);
        cfg_index <= REG_ALPHA;
        cfg_data <= alpha;
        @(posedge clk);
        cfg_index <= REG_CPR;
        cfg_data <= cpr_val;
        @(posedge clk);
        cfg_index <= REG_INDEX;
        cfg_data <= idx_on;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Send one pin sample transaction, inserting an idle gap between bursts
    task automatic send_sample(input logic [1:0] ab, input logic z, input logic [31:0] t);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, max_burst);
            if (max_gap != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, max_gap)) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        a_level <= ab[1];
        b_level <= ab[0];
        z_level <= z;
        now_us <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        pins_ab = ab;
        stamp = t;
    endtask

    // Stop sending, wait for every pending report, then let the block settle
    task automatic quiesce();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (open_reports != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Mostly clean quadrature walks, some holds, double flips and noise
    task automatic random_sample(input logic [31:0] win_len);
        int          roll;
        logic [1:0]  ab;
        logic        z;
        logic [31:0] step;
        roll = $urandom_range(0, 99);
        if (roll < 72)
        begin
            if ($urandom_range(0, 11) == 0)
                run_fwd = !run_fwd;
            ab = gray_next(pins_ab, run_fwd);
        end
        else if (roll < 84)
            ab = pins_ab;
        else if (roll < 94)
            ab = ~pins_ab;
        else
            ab = 2'($urandom_range(0, 3));
        z = ($urandom_range(0, 9) == 0);
        roll = $urandom_range(0, 99);
        if (roll < 20)
            step = 32'd0;
        else if (roll < 98)
            step = $urandom_range(1, win_len / 4 + 1);
        else
            step = $urandom();
        send_sample(ab, z, stamp + step);
    endtask

    initial
    begin
        logic [31:0] win_len;
        logic [31:0] alpha;
        logic [31:0] cpr_val;
        logic [31:0] idx_on;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // index detection off: a rising index pin leaves the flag clear
        load_config(32'd1, 32'd65536, 32'd1, 32'd0);
        send_sample(2'b00, 1'b0, 32'd0);
        send_sample(2'b00, 1'b1, 32'd3);
        quiesce();

        // first edge measured from time zero, with an index rise
        load_config(32'd1, 32'd65536, 32'd1, 32'd1);
        send_sample(2'b10, 1'b1, 32'd5);
        // B alone once, then A alone and both pins at once, each in both senses
        send_sample(2'b11, 1'b0, 32'd5);
        send_sample(2'b01, 1'b0, 32'd5);
        send_sample(2'b10, 1'b0, 32'd5);
        send_sample(2'b00, 1'b0, 32'd5);
        send_sample(2'b11, 1'b0, 32'd5);
        send_sample(2'b01, 1'b0, 32'd5);
        send_sample(2'b01, 1'b0, 32'd6);
        // many counts within one microsecond: rate and rpm saturate
        repeat (10) send_sample(gray_next(pins_ab, 1'b1), 1'b0, 32'd7);
        send_sample(pins_ab, 1'b0, 32'd8);
        quiesce();

        // zero window, zero weight, zero counts per revolution
        load_config(32'd0, 32'd0, 32'd0, 32'd1);
        send_sample(pins_ab, 1'b0, 32'd20);
        send_sample(gray_next(pins_ab, 1'b0), 1'b0, 32'd20);
        quiesce();

        // widest window, weight above one, widest counts per revolution
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        send_sample(pins_ab, 1'b1, 32'd25);
        send_sample(pins_ab, 1'b0, 32'd19);

        for (int ph = 0; ph < RandomPhases; ph++)
        begin
            quiesce();
            if (ph == 0)
            begin
                win_len = 32'd1;
                alpha = 32'd65536;
                cpr_val = 32'd1;
                idx_on = 32'd1;
                max_gap = 0;
                max_burst = 64;
                stall_mode = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       win_len = 32'd1;
                    1:       win_len = $urandom_range(2, 40);
                    default: win_len = $urandom_range(40, 400);
                endcase
                case ($urandom_range(0, 4))
                    0:       alpha = 32'd0;
                    1:       alpha = 32'd65536;
                    2:       alpha = 32'd19661;
                    3:       alpha = $urandom_range(65537, 131071);
                    default: alpha = $urandom_range(0, 65536);
                endcase
                case ($urandom_range(0, 3))
                    0:       cpr_val = 32'd0;
                    1:       cpr_val = 32'd1;
                    2:       cpr_val = 32'd65535;
                    default: cpr_val = $urandom_range(2, 8192);
                endcase
                idx_on = $urandom_range(0, 1);
                max_gap = $urandom_range(1, 12);
                max_burst = $urandom_range(1, 24);
                stall_mode = (ph == 1) ? 2 : $urandom_range(0, 2);
            end
            load_config(win_len, alpha, cpr_val, idx_on);
            stamp = (ph == 2) ? 32'hFFFF_FF00 : $urandom();

            for (int n = 0; n < PhaseItems; n++)
            begin
                // occasional fast run of edges at one timestamp
                if ($urandom_range(0, 39) == 0)
                    repeat ($urandom_range(9, 14))
                        send_sample(gray_next(pins_ab, run_fwd), 1'b0, stamp);
                random_sample(win_len);
            end
        end

        quiesce();
        if (mismatches == 0 && open_reports == 0)
            $display("tb_quadrature_decoder_speed_estimator: done, clean");
        else
            $display("tb_quadrature_decoder_speed_estimator: done, errors");
        $finish;
    end

endmodule
